@@ rtl/core/gnsu_pkg.sv @@
// Package for the sum-of-uniforms Gaussian noise source.
// Holds generator constants, field widths and register indexes; no dependencies.
package gnsu_pkg;

	// Generator word and its linear congruential step
	localparam int unsigned WordW  = 32;
	localparam logic [WordW-1:0] LcgMul = 32'd1664525;
	localparam logic [WordW-1:0] LcgInc = 32'd1013904223;

	// Uniform fractions: low bits of each word, twelve per sample
	localparam int unsigned FracW     = 23;
	localparam int unsigned UniformN  = 12;
	localparam int unsigned CountW    = 4;
	localparam int unsigned SumW      = 27;

	// Centered sum, gain and output sample
	localparam int unsigned NoiseW    = 28;
	localparam int unsigned GainW     = 16;
	localparam int unsigned GainShift = 15;
	localparam int unsigned ProdW     = NoiseW + GainW + 1;
	localparam logic signed [NoiseW-1:0] CenterOffset = 28'sd50331648;

	// Configuration port
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 32;
	localparam logic [CfgIdxW-1:0] RegGain = 2'd0;
	localparam logic [CfgIdxW-1:0] RegSeed = 2'd1;
	localparam logic [WordW-1:0]   SeedReset = 32'd1;

endpackage

@@ rtl/core/gaussian_noise_sum_of_uniforms.sv @@
// Gaussian noise source: LCG, twelve-uniform accumulator and gain scaling.
// Depends on gnsu_pkg for constants and widths.
//
// Each tick transaction with tick high and a nonzero gain yields one noise sample:
// the 32-bit generator word is stepped twelve times through a single shared
// multiply-add unit (one step per cycle), the low 23 bits of each new word are
// summed, the sum is centered by 6*2^23, scaled by the Q1.15 gain and shifted
// right by 15 with rounding toward minus infinity. From acceptance to the next
// acceptance a sample passes the generator steps, a centering state, the gain
// multiply and an output load, which waits for a free output. The input stalls
// during that time; a finished sample waits in the output register while the
// next tick is accepted. A tick with tick low, or while gain is zero, gives no
// sample and leaves the generator word unchanged. Writing seed reloads the
// generator word at once; write registers only while the block is idle.
module gaussian_noise_sum_of_uniforms (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              tick,
	// noise channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [gnsu_pkg::NoiseW-1:0] noise,
	// configuration write port
	input  logic                              wr_en,
	input  logic [gnsu_pkg::CfgIdxW-1:0]      wr_index,
	input  logic [gnsu_pkg::CfgDataW-1:0]     wr_data
);
	import gnsu_pkg::*;

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StRun    = 3'd1;
	localparam logic [2:0] StCenter = 3'd2;
	localparam logic [2:0] StScale  = 3'd3;
	localparam logic [2:0] StDone   = 3'd4;

	logic [2:0]               state_q;
	logic [CountW-1:0]        count_q;
	logic [WordW-1:0]         word_q;
	logic [GainW-1:0]         gain_q;
	logic [SumW-1:0]          sum_q;
	logic signed [NoiseW-1:0] centered_q;
	logic signed [ProdW-1:0]  prod_q;
	logic signed [NoiseW-1:0] noise_q;
	logic                     out_valid_q;

	logic [WordW-1:0]         lcg_next;
	logic [SumW-1:0]          sum_final;
	logic signed [ProdW-1:0]  prod_next;
	logic                     in_take;
	logic                     out_free;

	// Shared generator step unit
	assign lcg_next  = WordW'(word_q * LcgMul + LcgInc);
	assign sum_final = sum_q + SumW'(word_q[FracW-1:0]);
	assign prod_next = $signed({{(ProdW-NoiseW){centered_q[NoiseW-1]}}, centered_q})
		* $signed({{(ProdW-GainW){1'b0}}, gain_q});

	assign in_stall  = (state_q != StIdle);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign noise     = noise_q;

	// Sequencer, generator word and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			count_q     <= '0;
			word_q      <= SeedReset;
			gain_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise the output flag on a loaded sample, drop it once its transaction completes
			if (state_q == StDone && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				StIdle: begin
					if (wr_en && wr_index == RegGain) begin
						gain_q <= wr_data[GainW-1:0];
					end
					if (wr_en && wr_index == RegSeed) begin
						word_q <= wr_data[WordW-1:0];
					end
					if (in_take && tick && gain_q != '0) begin
						count_q <= '0;
						state_q <= StRun;
					end
				end
				StRun: begin
					word_q  <= lcg_next;
					count_q <= count_q + 1'b1;
					if (count_q == CountW'(UniformN - 1)) begin
						state_q <= StCenter;
					end
				end
				StCenter: begin
					state_q <= StScale;
				end
				StScale: begin
					state_q <= StDone;
				end
				StDone: begin
					// hold the sample until the output register is free
					if (out_free) begin
						state_q <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	// Datapath: accumulate fractions, center, scale, load output
	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				sum_q <= '0;
			end
			StRun: begin
				// add the previous step's fraction; the last one joins at centering
				if (count_q != '0) begin
					sum_q <= sum_final;
				end
			end
			StCenter: begin
				centered_q <= $signed({1'b0, sum_final}) - CenterOffset;
			end
			StScale: begin
				prod_q <= prod_next;
			end
			StDone: begin
				if (out_free) begin
					noise_q <= prod_q[GainShift +: NoiseW];
				end
			end
			default: begin
			end
		endcase
	end

endmodule
